### hw/rtl/rls_pkg.sv
// rls_pkg: shared types for the rgb lightness and saturation pipeline
// no dependencies; imported by every rls module and the top level
`default_nettype none

package rls_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages = DivSteps / StepsPerStage;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    chan_t mx;
    chan_t mn;
  } extent_t;

  // long division word: partial remainder, remaining dividend bits shifting
  // out at the top while quotient bits shift in at the bottom
  typedef struct packed {
    chan_t light;
    chan_t den;
    chan_t rem;
    chan_t low;
  } div_t;

  // valid and ready of the handshake from one stage to the next
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

`default_nettype wire

### hw/rtl/rls_minmax.sv
// rls_minmax: first stage, largest and smallest channel of the pixel
// depends on rls_pkg
`default_nettype none

module rls_minmax (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rls_pkg::pixel_t in_pix,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rls_pkg::extent_t    out_ext
);
  import rls_pkg::*;

  logic    valid_r;
  extent_t ext_r;
  extent_t ext_nxt;
  chan_t   mx_rg;
  chan_t   mn_rg;

  always_comb begin
    mx_rg = (in_pix.green > in_pix.red) ? in_pix.green : in_pix.red;
    mn_rg = (in_pix.green < in_pix.red) ? in_pix.green : in_pix.red;
    ext_nxt.mx = (in_pix.blue > mx_rg) ? in_pix.blue : mx_rg;
    ext_nxt.mn = (in_pix.blue < mn_rg) ? in_pix.blue : mn_rg;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_ext   = ext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ext_r <= ext_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rls_prep.sv
// rls_prep: second stage, lightness, divisor and scaled chroma dividend
// depends on rls_pkg
`default_nettype none

module rls_prep (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rls_pkg::extent_t in_ext,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rls_pkg::div_t        out_div
);
  import rls_pkg::*;

  localparam logic [ChanW:0] DenTop = (ChanW+1)'(510);
  localparam chan_t          HalfLevel = ChanW'(128);

  logic             valid_r;
  div_t             div_r;
  div_t             div_nxt;
  logic [ChanW:0]   sum;
  logic [ChanW:0]   den_hi;
  chan_t            chroma;
  logic [2*ChanW-1:0] dividend;

  always_comb begin
    sum      = {1'b0, in_ext.mx} + {1'b0, in_ext.mn};
    chroma   = in_ext.mx - in_ext.mn;
    den_hi   = DenTop - sum;
    // 255 * chroma
    dividend = {chroma, {ChanW{1'b0}}} - {{ChanW{1'b0}}, chroma};
    div_nxt.light = sum[ChanW:1];
    if (chroma == '0) begin
      // grey: zero dividend over one keeps the quotient at zero
      div_nxt.den = ChanW'(1);
    end else if (sum[ChanW:1] < HalfLevel) begin
      div_nxt.den = sum[ChanW-1:0];
    end else begin
      div_nxt.den = den_hi[ChanW-1:0];
    end
    div_nxt.rem = dividend[2*ChanW-1:ChanW];
    div_nxt.low = dividend[ChanW-1:0];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_div   = div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      div_r <= div_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rls_div_stage.sv
// rls_div_stage: one pipeline stage of restoring division, two quotient bits
// depends on rls_pkg
`default_nettype none

module rls_div_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire rls_pkg::div_t in_div,
  output logic              out_valid,
  input  wire logic         out_ready,
  output rls_pkg::div_t     out_div
);
  import rls_pkg::*;

  logic valid_r;
  div_t div_r;
  div_t div_nxt;

  function automatic div_t div_step(input div_t d);
    div_t          o;
    logic [ChanW:0] t;
    o = d;
    t = {d.rem, d.low[ChanW-1]};
    if (t >= {1'b0, d.den}) begin
      t = t - {1'b0, d.den};
      o.low = {d.low[ChanW-2:0], 1'b1};
    end else begin
      o.low = {d.low[ChanW-2:0], 1'b0};
    end
    o.rem = t[ChanW-1:0];
    return o;
  endfunction

  always_comb begin
    div_nxt = in_div;
    for (int i = 0; i < StepsPerStage; i++) begin
      div_nxt = div_step(div_nxt);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_div   = div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      div_r <= div_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rgb_lightness_saturation.sv
// rgb_lightness_saturation: hsl lightness and saturation of 8-bit rgb pixels
// depends on rls_pkg, rls_minmax, rls_prep and rls_div_stage
// pipeline: min/max, prep, then the divide stages, each registered
// throughput: one pixel per cycle unless the output stalls; the divider is four stages of two quotient bits
// every stage stalls only when its successor holds a result that is not taken
// reset: synchronous active-low rst_n clears all stage valid bits
`default_nettype none

module rgb_lightness_saturation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // lightness[7:0], saturation[15:8]
);
  import rls_pkg::*;

  pixel_t  pix;
  extent_t ext;
  hs_t     mm_hs;
  hs_t     pp_hs;
  hs_t     dv_hs [DivStages];
  div_t    pp_div;
  div_t    dv_div [DivStages];

  assign pix.red   = in_tdata[7:0];
  assign pix.green = in_tdata[15:8];
  assign pix.blue  = in_tdata[23:16];

  rls_minmax u_minmax (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (pix),
    .out_valid (mm_hs.valid),
    .out_ready (mm_hs.ready),
    .out_ext   (ext)
  );

  rls_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mm_hs.valid),
    .in_ready  (mm_hs.ready),
    .in_ext    (ext),
    .out_valid (pp_hs.valid),
    .out_ready (pp_hs.ready),
    .out_div   (pp_div)
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    if (s == 0) begin : g_first
      rls_div_stage u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pp_hs.valid),
        .in_ready  (pp_hs.ready),
        .in_div    (pp_div),
        .out_valid (dv_hs[s].valid),
        .out_ready (dv_hs[s].ready),
        .out_div   (dv_div[s])
      );
    end else begin : g_next
      rls_div_stage u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_hs[s-1].valid),
        .in_ready  (dv_hs[s-1].ready),
        .in_div    (dv_div[s-1]),
        .out_valid (dv_hs[s].valid),
        .out_ready (dv_hs[s].ready),
        .out_div   (dv_div[s])
      );
    end
  end

  assign dv_hs[DivStages-1].ready = out_tready;
  assign out_tvalid = dv_hs[DivStages-1].valid;
  assign out_tdata  = {dv_div[DivStages-1].low, dv_div[DivStages-1].light};

  a_extent_order: assert property (@(posedge clk) disable iff (!rst_n)
    mm_hs.valid |-> ext.mx >= ext.mn)
    else $error("max channel below min channel");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pp_hs.valid |-> (pp_div.den != '0) && (pp_div.rem < pp_div.den))
    else $error("divider start word out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> dv_div[DivStages-1].rem < dv_div[DivStages-1].den)
    else $error("final remainder not below divisor");

endmodule

`default_nettype wire
